[rtl/mlpc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mlpc_pkg;

    // Sizing
    localparam int MAX_LEDS_DEF = 8;
    localparam int CFG_ADDR_W   = 5;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_LED_COUNT   = 3'd0;
    localparam logic [2:0] REG_INVERT_MASK = 3'd1;
    localparam logic [2:0] REG_SHORT_MS    = 3'd2;
    localparam logic [2:0] REG_MEDIUM_MS   = 3'd3;
    localparam logic [2:0] REG_LONG_MS     = 3'd4;

    // Register reset values
    localparam logic [3:0]  RST_LED_COUNT   = 4'd1;
    localparam logic [7:0]  RST_INVERT_MASK = 8'd0;
    localparam logic [15:0] RST_SHORT_MS    = 16'd100;
    localparam logic [15:0] RST_MEDIUM_MS   = 16'd500;
    localparam logic [15:0] RST_LONG_MS     = 16'd1000;

    // Request types
    localparam logic REQ_POLL = 1'b0;
    localparam logic REQ_SET  = 1'b1;

    // Status codes
    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_BAD_INDEX = 1'b1;

    // LED modes
    localparam logic [3:0] MODE_OFF        = 4'd0;
    localparam logic [3:0] MODE_ON         = 4'd1;
    localparam logic [3:0] MODE_SHORT      = 4'd2;
    localparam logic [3:0] MODE_SHORT_INV  = 4'd3;
    localparam logic [3:0] MODE_MEDIUM     = 4'd4;
    localparam logic [3:0] MODE_MEDIUM_INV = 4'd5;
    localparam logic [3:0] MODE_LONG       = 4'd6;
    localparam logic [3:0] MODE_LONG_INV   = 4'd7;
    localparam logic [3:0] MODE_BLINK      = 4'd8;
    localparam logic [3:0] MODE_RUN        = 4'd9;
    localparam logic [3:0] MODE_RUN_SHADOW = 4'd10;

    // Input item
    typedef struct packed {
        logic        req_type;
        logic [15:0] elapsed_ms;
        logic [7:0]  led_index;
        logic [3:0]  led_mode;
    } t_req;

    // Result item
    typedef struct packed {
        logic [7:0] pin_levels;
        logic       status;
    } t_res;

    // Per-LED step: state read back plus settings
    typedef struct packed {
        logic [31:0] phase;
        logic [3:0]  cur_mode;
        logic [3:0]  pend_mode;
        logic [15:0] elapsed;
        logic [31:0] chase;
        logic [3:0]  led_n;
        logic [7:0]  invert;
        logic [15:0] short_ms;
        logic [15:0] medium_ms;
        logic [15:0] long_ms;
    } t_step_in;

    // Per-LED step: state to write back plus pin level
    typedef struct packed {
        logic [31:0] phase;
        logic [3:0]  mode;
        logic [31:0] chase;
        logic        level;
    } t_step_out;

endpackage

`default_nettype wire

[rtl/mlpc_led_step.sv]
`timescale 1ns / 1ps
`default_nettype none

module mlpc_led_step #(
    parameter int MAX_LEDS = mlpc_pkg::MAX_LEDS_DEF
) (
    input  wire  logic [((MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1)-1:0] i_idx,
    input  wire  logic [((MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1)-1:0] i_pos,
    input  wire  mlpc_pkg::t_step_in                                 i_step,
    output logic [((MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1)-1:0]       o_pos,
    output mlpc_pkg::t_step_out                                      o_step
);

    localparam int IW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;

    // One LED: advance counter, adopt mode, work out the pin level
    always_comb begin
        logic [31:0] phase;
        logic [31:0] chase;
        logic [31:0] pos_w;
        logic [15:0] half;
        logic        lit;
        logic        inv;

        phase = i_step.phase + 32'(i_step.elapsed);
        chase = i_step.chase;
        pos_w = 32'(i_pos);
        half  = i_step.short_ms;
        lit   = 1'b0;
        inv   = 1'b0;

        // mode change restarts this LED and the shared chase
        if (i_step.pend_mode != i_step.cur_mode) begin
            phase = '0;
            chase = '0;
        end

        case (i_step.pend_mode)
            mlpc_pkg::MODE_ON: begin
                lit = 1'b1;
            end
            mlpc_pkg::MODE_SHORT, mlpc_pkg::MODE_SHORT_INV,
            mlpc_pkg::MODE_MEDIUM, mlpc_pkg::MODE_MEDIUM_INV,
            mlpc_pkg::MODE_LONG, mlpc_pkg::MODE_LONG_INV: begin
                if (i_step.pend_mode == mlpc_pkg::MODE_MEDIUM ||
                    i_step.pend_mode == mlpc_pkg::MODE_MEDIUM_INV) begin
                    half = i_step.medium_ms;
                end else if (i_step.pend_mode == mlpc_pkg::MODE_LONG ||
                             i_step.pend_mode == mlpc_pkg::MODE_LONG_INV) begin
                    half = i_step.long_ms;
                end
                if (phase < 32'(half)) begin
                    lit = 1'b1;
                end else if (phase >= {15'd0, half, 1'b0}) begin
                    phase = '0;
                end
                // odd codes are the inverted variants
                lit = lit ^ i_step.pend_mode[0];
            end
            mlpc_pkg::MODE_BLINK: begin
                if (phase < 32'(i_step.short_ms)) begin
                    lit = 1'b1;
                end else if (phase >= 32'(i_step.long_ms)) begin
                    phase = '0;
                end
            end
            mlpc_pkg::MODE_RUN, mlpc_pkg::MODE_RUN_SHADOW: begin
                chase = chase + 32'(i_step.elapsed);
                if (chase > 32'(i_step.medium_ms)) begin
                    chase = '0;
                    pos_w = pos_w + 32'd1;
                end
                if (pos_w >= 32'(i_step.led_n)) begin
                    pos_w = '0;
                end
                lit = (pos_w == 32'(i_idx));
                if (i_step.pend_mode == mlpc_pkg::MODE_RUN_SHADOW) begin
                    lit = ~lit;
                end
            end
            mlpc_pkg::MODE_OFF: begin
                lit = 1'b0;
            end
            default: begin
                lit = 1'b0;
            end
        endcase

        // only the first eight LEDs have an invert bit
        for (int b = 0; b < 8; b++) begin
            if (32'(i_idx) == b) begin
                inv = i_step.invert[b];
            end
        end

        o_step.phase = phase;
        o_step.mode  = i_step.pend_mode;
        o_step.chase = chase;
        o_step.level = inv ^ lit;
        o_pos        = IW'(pos_w);
    end

endmodule

`default_nettype wire

[rtl/multi_led_pattern_controller_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Multi-LED pattern controller.
// Command channel: an item (i_req) is taken on a clock edge with start high
// and busy low. A set-mode item stores a pending mode for one LED; its result
// (o_valid, o_res) appears in the next cycle, status flags an index not below
// the number of LEDs in use. A poll item walks those LEDs, one LED per cycle,
// through the per-LED state memory (read, update, write back). Its result is
// registered with the last LED, and busy is high while the walk runs; with
// no LED in use it answers in the next cycle, like a set-mode item.
// Sustained rate: one set-mode item per cycle; a poll holds busy high, so no
// new item is taken until its walk ends. Each result is shown for exactly
// one cycle; the receiver cannot stall. Settings are written through the APB
// port; the user must do so only while the block is idle, which the block
// does not enforce. Reset (synchronous, active low) restores register defaults,
// turns all pins low and marks every LED memory entry as unwritten, so it
// reads as off with a zero counter. No clearing pass is needed.

module multi_led_pattern_controller_core #(
    parameter int MAX_LEDS = mlpc_pkg::MAX_LEDS_DEF
) (
    input  wire  logic                          i_clk,
    input  wire  logic                          i_rst_n,
    // command channel
    input  wire  logic                          start,
    output logic                                busy,
    input  wire  mlpc_pkg::t_req                i_req,
    output logic                                o_valid,
    output mlpc_pkg::t_res                      o_res,
    // configuration port
    input  wire  logic                          psel,
    input  wire  logic                          penable,
    input  wire  logic                          pwrite,
    input  wire  logic [mlpc_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire  logic [31:0]                   pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    localparam int IW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    // configuration registers
    logic [3:0]  r_led_count;
    logic [7:0]  r_invert;
    logic [15:0] r_short_ms;
    logic [15:0] r_medium_ms;
    logic [15:0] r_long_ms;

    // control and shared state
    logic                r_state;
    logic [IW-1:0]       r_proc_idx;
    logic [15:0]         r_elapsed;
    logic [31:0]         r_chase;
    logic [IW-1:0]       r_pos;
    logic [7:0]          r_pin;
    logic [MAX_LEDS-1:0] r_led_vld;
    logic [MAX_LEDS-1:0] r_pend_vld;
    logic                r_valid;
    mlpc_pkg::t_res      r_res;

    // memories: {phase, current mode} and pending mode
    logic [35:0] mem_led  [MAX_LEDS];
    logic [3:0]  mem_pend [MAX_LEDS];
    logic [35:0] r_rd_led;
    logic [3:0]  r_rd_pend;

    logic                 w_acc;
    logic                 w_cfg_we;
    logic [3:0]           w_n;
    logic                 w_idx_ok;
    logic                 w_last;
    logic [IW-1:0]        w_rd_addr;
    logic [IW-1:0]        w_set_addr;
    logic                 w_pend_we;
    logic                 w_led_we;
    logic [7:0]           n_pin;
    logic [IW-1:0]        w_pos_next;
    mlpc_pkg::t_step_in   w_step_in;
    mlpc_pkg::t_step_out  w_step_out;

    assign w_acc    = start & ~busy;
    assign w_cfg_we = psel & penable & pwrite & pready;
    assign busy     = (r_state == ST_RUN);
    assign pready   = 1'b1;
    assign o_valid  = r_valid;
    assign o_res    = r_res;

    // LEDs in use: count clamped to the memory depth
    assign w_n = (32'(r_led_count) > 32'(MAX_LEDS)) ? 4'(MAX_LEDS) : r_led_count;

    assign w_idx_ok   = (32'(i_req.led_index) < 32'(w_n));
    assign w_set_addr = IW'(i_req.led_index);
    assign w_pend_we  = (r_state == ST_IDLE) && w_acc &&
                        (i_req.req_type == mlpc_pkg::REQ_SET) && w_idx_ok;
    assign w_led_we   = (r_state == ST_RUN);
    assign w_last     = (32'(r_proc_idx) == (32'(w_n) - 32'd1));
    assign w_rd_addr  = (r_state == ST_IDLE) ? '0 : (r_proc_idx + IW'(1));

    // register read-back
    always_comb begin
        prdata = '0;
        case (paddr[4:2])
            mlpc_pkg::REG_LED_COUNT:   prdata = 32'(r_led_count);
            mlpc_pkg::REG_INVERT_MASK: prdata = 32'(r_invert);
            mlpc_pkg::REG_SHORT_MS:    prdata = 32'(r_short_ms);
            mlpc_pkg::REG_MEDIUM_MS:   prdata = 32'(r_medium_ms);
            mlpc_pkg::REG_LONG_MS:     prdata = 32'(r_long_ms);
            default:                   prdata = '0;
        endcase
    end

    // memory ports: one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (w_led_we) begin
            mem_led[r_proc_idx] <= {w_step_out.phase, w_step_out.mode};
        end
        r_rd_led <= mem_led[w_rd_addr];
        if (w_pend_we) begin
            mem_pend[w_set_addr] <= i_req.led_mode;
        end
        r_rd_pend <= mem_pend[w_rd_addr];
    end

    // step inputs; unwritten entries read as zero / off
    always_comb begin
        w_step_in.phase     = r_led_vld[r_proc_idx] ? r_rd_led[35:4] : '0;
        w_step_in.cur_mode  = r_led_vld[r_proc_idx] ? r_rd_led[3:0] : mlpc_pkg::MODE_OFF;
        w_step_in.pend_mode = r_pend_vld[r_proc_idx] ? r_rd_pend : mlpc_pkg::MODE_OFF;
        w_step_in.elapsed   = r_elapsed;
        w_step_in.chase     = r_chase;
        w_step_in.led_n     = w_n;
        w_step_in.invert    = r_invert;
        w_step_in.short_ms  = r_short_ms;
        w_step_in.medium_ms = r_medium_ms;
        w_step_in.long_ms   = r_long_ms;
    end

    mlpc_led_step #(
        .MAX_LEDS (MAX_LEDS)
    ) u_step (
        .i_idx  (r_proc_idx),
        .i_pos  (r_pos),
        .i_step (w_step_in),
        .o_pos  (w_pos_next),
        .o_step (w_step_out)
    );

    // pin update for the LED in hand (LEDs past eight have no pin)
    always_comb begin
        for (int b = 0; b < 8; b++) begin
            n_pin[b] = (32'(r_proc_idx) == b) ? w_step_out.level : r_pin[b];
        end
    end

    // control sequencer and registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led_count <= mlpc_pkg::RST_LED_COUNT;
            r_invert    <= mlpc_pkg::RST_INVERT_MASK;
            r_short_ms  <= mlpc_pkg::RST_SHORT_MS;
            r_medium_ms <= mlpc_pkg::RST_MEDIUM_MS;
            r_long_ms   <= mlpc_pkg::RST_LONG_MS;
            r_state     <= ST_IDLE;
            r_proc_idx  <= '0;
            r_chase     <= '0;
            r_pos       <= '0;
            r_pin       <= '0;
            r_led_vld   <= '0;
            r_pend_vld  <= '0;
            r_valid     <= 1'b0;
        end else begin
            // register writes
            if (w_cfg_we) begin
                case (paddr[4:2])
                    mlpc_pkg::REG_LED_COUNT:   r_led_count <= pwdata[3:0];
                    mlpc_pkg::REG_INVERT_MASK: r_invert    <= pwdata[7:0];
                    mlpc_pkg::REG_SHORT_MS:    r_short_ms  <= pwdata[15:0];
                    mlpc_pkg::REG_MEDIUM_MS:   r_medium_ms <= pwdata[15:0];
                    mlpc_pkg::REG_LONG_MS:     r_long_ms   <= pwdata[15:0];
                    default: ;
                endcase
            end

            r_valid <= 1'b0;

            case (r_state)
                ST_IDLE: begin
                    if (w_acc) begin
                        if (i_req.req_type == mlpc_pkg::REQ_SET) begin
                            if (w_idx_ok) begin
                                r_pend_vld[w_set_addr] <= 1'b1;
                            end
                            r_valid          <= 1'b1;
                            r_res.pin_levels <= r_pin;
                            r_res.status     <= w_idx_ok ? mlpc_pkg::STATUS_OK
                                                         : mlpc_pkg::STATUS_BAD_INDEX;
                        end else if (w_n == 4'd0) begin
                            r_valid          <= 1'b1;
                            r_res.pin_levels <= r_pin;
                            r_res.status     <= mlpc_pkg::STATUS_OK;
                        end else begin
                            r_elapsed  <= i_req.elapsed_ms;
                            r_proc_idx <= '0;
                            r_state    <= ST_RUN;
                        end
                    end
                end
                ST_RUN: begin
                    // write back this LED while the next one is read
                    r_led_vld[r_proc_idx] <= 1'b1;
                    r_chase <= w_step_out.chase;
                    r_pos   <= w_pos_next;
                    r_pin   <= n_pin;
                    if (w_last) begin
                        r_state          <= ST_IDLE;
                        r_valid          <= 1'b1;
                        r_res.pin_levels <= n_pin;
                        r_res.status     <= mlpc_pkg::STATUS_OK;
                    end else begin
                        r_proc_idx <= r_proc_idx + IW'(1);
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
